// ===== rtl/indexed_list_store_defines.svh =====
// Assertion macros shared by the indexed list store modules.
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ILS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication, disabled during reset.
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define ILS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ils_pkg.sv =====
// Shared constants and types for the indexed list store.
package ils_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // Operation codes
  localparam logic [OP_W-1:0] OP_GET      = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL      = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [VALUE_W-1:0] NEG_ONE = '1;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;
  } ils_cmd_t;

endpackage

// ===== rtl/ils_ctrl.sv =====
// Handshake controller: accepts transactions and holds the result register valid.
`include "indexed_list_store_defines.svh"

module ils_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ils_pkg::ils_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_t;

  state_t state_r;

  // Take a new transaction when the result slot is empty or being drained
  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign out_valid = (state_r == S_HOLD);
  assign cmd.exec  = in_valid && in_ready;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.exec) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!cmd.exec && out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `ILS_ASSERT_NEXT(a_exec_holds_result, clk, rst_n, cmd.exec, state_r == S_HOLD)
  `ILS_ASSERT_NEXT(a_wait_keeps_result, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

// ===== rtl/ils_dp.sv =====
// Datapath: element cells, length counter, operation decode and result register.
`include "indexed_list_store_defines.svh"

module ils_dp #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ils_pkg::ils_cmd_t                   cmd,
  input  logic [ils_pkg::OP_W-1:0]            in_op,
  input  logic [ils_pkg::POS_W-1:0]           in_position,
  input  logic signed [ils_pkg::VALUE_W-1:0]  in_value,
  output logic signed [ils_pkg::VALUE_W-1:0]  out_read_value,
  output logic [ils_pkg::STATUS_W-1:0]        out_status,
  output logic [ils_pkg::COUNT_W-1:0]         out_count
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);
  localparam int CW = ils_pkg::COUNT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic signed [ils_pkg::VALUE_W-1:0] elem_r [CAPACITY];
  logic [LW-1:0]                      len_r;
  logic [LW-1:0]                      len_nxt;

  logic signed [ils_pkg::VALUE_W-1:0] rd_nxt;
  logic [ils_pkg::STATUS_W-1:0]       st_nxt;
  logic                               do_ins;
  logic                               do_del;
  logic [CW-1:0]                      at_pos;
  logic [CW-1:0]                      len_c;
  logic [CW-1:0]                      pos_c;

  logic signed [ils_pkg::VALUE_W-1:0] rd_r;
  logic [ils_pkg::STATUS_W-1:0]       st_r;
  logic [CW-1:0]                      cnt_r;

  assign len_c = CW'(len_r);
  assign pos_c = CW'(in_position);

  // Decode the operation and check range and fill
  always_comb begin
    rd_nxt = ils_pkg::NEG_ONE;
    st_nxt = ils_pkg::ST_DONE;
    do_ins = 1'b0;
    do_del = 1'b0;
    at_pos = pos_c;
    unique case (in_op)
      ils_pkg::OP_GET: begin
        if (pos_c < len_c) begin
          rd_nxt = elem_r[in_position[PW-1:0]];
        end else begin
          st_nxt = ils_pkg::ST_RANGE;
        end
      end
      ils_pkg::OP_INS_HEAD, ils_pkg::OP_INS_TAIL, ils_pkg::OP_INS_AT: begin
        if (in_op == ils_pkg::OP_INS_HEAD) begin
          at_pos = '0;
        end else if (in_op == ils_pkg::OP_INS_TAIL) begin
          at_pos = len_c;
        end
        if (at_pos > len_c) begin
          st_nxt = ils_pkg::ST_RANGE;
        end else if (len_c >= CAP_C) begin
          st_nxt = ils_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      ils_pkg::OP_DEL: begin
        if (pos_c < len_c) begin
          do_del = 1'b1;
        end else begin
          st_nxt = ils_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // Step the length
  always_comb begin
    len_nxt = len_r;
    if (do_ins) begin
      len_nxt = len_r + 1'b1;
    end else if (do_del) begin
      len_nxt = len_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cmd.exec) begin
      len_r <= len_nxt;
    end
  end

  // Each cell takes the new value, its lower neighbor on insert or its upper on delete
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int PREV = (g > 0) ? g - 1 : 0;
    localparam int NEXT = (g < CAPACITY - 1) ? g + 1 : g;
    localparam logic [CW-1:0] IDX = CW'(g);
    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (do_ins && (IDX == at_pos)) begin
          elem_r[g] <= in_value;
        end else if (do_ins && (IDX > at_pos)) begin
          elem_r[g] <= elem_r[PREV];
        end else if (do_del && (IDX >= pos_c)) begin
          elem_r[g] <= elem_r[NEXT];
        end
      end
    end
  end

  // Hold the result for the output channel
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r  <= rd_nxt;
      st_r  <= st_nxt;
      cnt_r <= CW'(len_nxt);
    end
  end

  assign out_read_value = rd_r;
  assign out_status     = st_r;
  assign out_count      = cnt_r;

  `ILS_ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1, len_r <= LW'(CAPACITY))
  `ILS_ASSERT_NEXT(a_ins_grows, clk, rst_n, cmd.exec && do_ins, len_r == LW'($past(len_r) + 1'b1))
  `ILS_ASSERT_NEXT(a_del_shrinks, clk, rst_n, cmd.exec && do_del, len_r == LW'($past(len_r) - 1'b1))
  `ILS_ASSERT_NEXT(a_reject_keeps, clk, rst_n, cmd.exec && (st_nxt != ils_pkg::ST_DONE), $stable(len_r))

endmodule

// ===== rtl/indexed_list_store.sv =====
// Top level of the indexed list store: controller and datapath.
// Ordered store of up to CAPACITY signed 32-bit values. Each transaction
// (get, insert at head, insert at tail, insert before a position, delete at a
// position) is applied at once: every element cell loads its new value, its
// neighbor's value or keeps its own in parallel, and the result is registered.
// A new transaction is accepted in the same cycle the previous result is taken,
// so while out_ready is high the sustained rate is one transaction per cycle,
// and each result is valid in the cycle after its transaction is accepted. No
// clearing pass is needed after reset; only the length count is cleared.
module indexed_list_store #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ils_pkg::OP_W-1:0]            in_op,
  input  logic [ils_pkg::POS_W-1:0]           in_position,
  input  logic signed [ils_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ils_pkg::VALUE_W-1:0]  out_read_value,
  output logic [ils_pkg::STATUS_W-1:0]        out_status,
  output logic [ils_pkg::COUNT_W-1:0]         out_count
);

  ils_pkg::ils_cmd_t cmd;

  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ils_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the indexed list store: directed and random operation sequences.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int OP_LAST     = (1 << OP_W) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 24;
  localparam int TAIL_CYCLES = 4;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [OP_W-1:0]           in_op = '0;
  logic [POS_W-1:0]          in_position = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_read_value;
  logic [STATUS_W-1:0]       out_status;
  logic [COUNT_W-1:0]        out_count;

  // Shadow copy of the list contents and its length
  logic signed [VALUE_W-1:0] list_mem [CAP];
  logic [COUNT_W-1:0]        list_len = '0;
  list_result_t              pending_results [$];

  logic steady = 1'b0;
  logic in_random = 1'b0;
  int   fail_count = 0;
  int   cycle_count = 0;
  int   n_directed = 0;
  int   n_random = 0;
  int   n_full = 0;
  int   n_range = 0;
  int   peak_len = 0;

  indexed_list_store #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_value(out_read_value),
    .out_status    (out_status),
    .out_count     (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at random unless a steady stretch is running
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Apply one operation to the shadow list and return the result it should give
  function automatic list_result_t apply_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                            logic signed [VALUE_W-1:0] val);
    list_result_t r;
    int at;
    r.read_value = NEG_ONE;
    r.status     = ST_DONE;
    case (op)
      OP_GET: begin
        if (pos < list_len) r.read_value = list_mem[pos];
        else r.status = ST_RANGE;
      end
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
        at = (op == OP_INS_HEAD) ? 0 : (op == OP_INS_TAIL) ? int'(list_len) : int'(pos);
        if (at > int'(list_len)) begin
          r.status = ST_RANGE;
        end else if (int'(list_len) >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (int i = int'(list_len); i > at; i--) list_mem[i] = list_mem[i-1];
          list_mem[at] = val;
          list_len++;
        end
      end
      OP_DEL: begin
        if (pos < list_len) begin
          for (int i = int'(pos); i + 1 < int'(list_len); i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    r.count = list_len;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_RANGE) n_range++;
    if (int'(list_len) > peak_len) peak_len = int'(list_len);
    return r;
  endfunction

  // Present one transaction, hold it until accepted, then record its expected result
  task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic signed [VALUE_W-1:0] val);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_op(op, pos, val));
    if (in_random) n_random++;
    else n_directed++;
  endtask

  // Drop valid, wait for every outstanding result, then a quiet tail
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_value %0d status %0d count %0d",
               out_read_value, out_status, out_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_count);
          fail_count++;
        end
      end
    end
  end

  // Reads, deletes and inserts past the end of an empty list
  task automatic test_empty_store();
    send_item(OP_GET, 8'd0, 32'sd5);
    send_item(OP_DEL, 8'd255, 32'sd0);
    send_item(OP_INS_AT, 8'd1, 32'sd7);
  endtask

  // Fill with every insert kind, extreme values and an append by position
  task automatic test_fill_to_capacity();
    send_item(OP_INS_HEAD, 8'd0, 32'sh8000_0000);
    send_item(OP_INS_TAIL, 8'd255, 32'sh7FFF_FFFF);
    send_item(OP_INS_AT, 8'd2, 32'sd0);
    send_item(OP_INS_AT, 8'd1, NEG_ONE);
    while (int'(list_len) < CAP) send_item(OP_INS_TAIL, POS_W'($urandom()), $urandom());
  endtask

  // Inserts into a full list; the range check wins over the full check
  task automatic test_full_store();
    send_item(OP_INS_HEAD, 8'd0, 32'sd11);
    send_item(OP_INS_AT, POS_W'(CAP + 1), 32'sd12);
    send_item(OP_INS_AT, POS_W'(CAP), 32'sd13);
    send_item(OP_INS_TAIL, 8'd0, 32'sd14);
  endtask

  // Reads and deletes at the edges of the list
  task automatic test_positions();
    send_item(OP_GET, 8'd255, 32'sd0);
    send_item(OP_GET, POS_W'(CAP - 1), 32'sd0);
    send_item(OP_DEL, 8'd0, 32'sd0);
    send_item(OP_DEL, POS_W'(CAP - 1), 32'sd0);
    send_item(OP_GET, 8'd0, 32'sd0);
  endtask

  // Op codes past delete must change nothing
  task automatic test_unused_ops();
    for (int k = int'(OP_DEL) + 1; k <= OP_LAST; k++) begin
      send_item(OP_W'(k), POS_W'($urandom()), $urandom());
    end
  endtask

  // Mostly well-formed operations in blocks with a varying insert bias, plus noise
  task automatic test_random(int n_items);
    int done_items;
    int block;
    int ins_bias;
    int roll;
    int pick;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic signed [VALUE_W-1:0] val;
    done_items = 0;
    block = 0;
    in_random = 1'b1;
    while (done_items < n_items) begin
      ins_bias = $urandom_range(20, 80);
      steady = (block == 3);
      repeat (150) begin
        roll = $urandom_range(0, 99);
        val = $urandom();
        if ($urandom_range(0, 15) == 0) val = $urandom_range(0, 1) ? 32'sh7FFF_FFFF
                                                                   : 32'sh8000_0000;
        if (roll < 5) begin
          op  = OP_W'($urandom_range(int'(OP_DEL) + 1, OP_LAST));
          pos = POS_W'($urandom());
        end else if (roll < 15) begin
          op  = OP_W'($urandom_range(0, OP_LAST));
          pos = POS_W'($urandom());
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < ins_bias) begin
            case ($urandom_range(0, 2))
              0: op = OP_INS_HEAD;
              1: op = OP_INS_TAIL;
              default: op = OP_INS_AT;
            endcase
            pos = POS_W'($urandom_range(0, int'(list_len)));
          end else begin
            op  = (pick < ins_bias + (100 - ins_bias) / 2) ? OP_DEL : OP_GET;
            pos = (list_len == 0) ? POS_W'(0) : POS_W'($urandom_range(0, int'(list_len) - 1));
          end
        end
        send_item(op, pos, val);
        done_items++;
      end
      // Hold the sender until the block has caught up once
      if (block == 6) wait_drained();
      block++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_store();
    test_fill_to_capacity();
    test_full_store();
    test_positions();
    test_unused_ops();
    test_random(1950);
    wait_drained();
    $display("Ran %0d directed and %0d random transactions, peak fill %0d of %0d.",
             n_directed, n_random, peak_len, CAP);
    $display("Saw %0d full-store drops and %0d out-of-range rejects.", n_full, n_range);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ils_pkg.sv
rtl/ils_ctrl.sv
rtl/ils_dp.sv
rtl/indexed_list_store.sv
bench/tb.sv
